### hdl/pvm_pkg.sv
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types, codes and constants of the PCM voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

    // Default sizes
    localparam int MAX_VOICES_DEF    = 16;
    localparam int MAX_SOUNDS_DEF    = 64;
    localparam int SAMPLE_FRAMES_DEF = 65536;
    localparam int FRAC_BITS_DEF     = 16;

    // Command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_DEFINE = 2'd1;
    localparam logic [1:0] CMD_PLAY   = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    // Register map (word index)
    localparam logic REG_OUTPUT_RATE = 1'b0;

    // Output rate limits and reset
    localparam logic [17:0] RATE_RESET = 18'd44100;
    localparam logic [17:0] RATE_MIN   = 18'd8000;
    localparam logic [17:0] RATE_MAX   = 18'd192000;

    // Gain scaling: full scale is 255*255, reciprocal is floor(2^32 / 65025)
    localparam logic [15:0] GAIN_FULL  = 16'd65025;
    localparam logic [16:0] GAIN_RECIP = 17'd66051;
    localparam logic [7:0]  PAN_FULL   = 8'd255;

    localparam logic signed [17:0] MIX_MIN = -18'sd32768;
    localparam logic signed [17:0] MIX_MAX = 18'sd32767;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         sound_id;
        logic [15:0]        frame_address;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [15:0]        start_frame;
        logic [16:0]        length_frames;
        logic [18:0]        src_rate;
        logic [7:0]         volume;
        logic [7:0]         pan;
    } pvm_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic [1:0]         status;
        logic [4:0]         active_voices;
    } pvm_result_t;

    // Sound table entry
    typedef struct packed {
        logic [15:0] start;
        logic [16:0] len;
        logic [31:0] step;
    } pvm_sound_t;

    // Step divider request
    typedef struct packed {
        logic        start;
        logic [18:0] rate;
        logic [17:0] orate;
    } pvm_div_req_t;

    // Gain scaler request
    typedef struct packed {
        logic               start;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [15:0]        gain_l;
        logic [15:0]        gain_r;
    } pvm_scl_req_t;

endpackage

### hdl/pvm_ram.sv
// ----------------------------------------------------------------------------
// pvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/pvm_divider.sv
// ----------------------------------------------------------------------------
// pvm_divider
// Bit-serial restoring divider for the playback step:
// step = floor(sample_rate * 2^FRAC_BITS / clamp(output_rate)).
// ----------------------------------------------------------------------------
module pvm_divider #(
    parameter int FRAC_BITS = pvm_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pvm_pkg::pvm_div_req_t req,
    output logic                 done,
    output logic [31:0]          step
);
    import pvm_pkg::*;

    localparam int QW = 19 + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [17:0]   rem_reg, rem_next;
    logic [17:0]   dvs_reg, dvs_next;
    logic [18:0]   trial;
    logic [63:0]   quo_x;

    // One quotient bit per cycle; dividend shifts out as quotient shifts in
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[QW-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            dvd_next  = QW'(req.rate) << FRAC_BITS;
            rem_next  = '0;
            if (req.orate < RATE_MIN)
            begin
                dvs_next = RATE_MIN;
            end
            else if (req.orate > RATE_MAX)
            begin
                dvs_next = RATE_MAX;
            end
            else
            begin
                dvs_next = req.orate;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 18'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[17:0];
                dvd_next = {dvd_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quo_x = 64'(dvd_reg);
    assign step  = quo_x[31:0];
    assign done  = done_reg;

endmodule

### hdl/pvm_scaler.sv
// ----------------------------------------------------------------------------
// pvm_scaler
// Three-stage gain scaler: trunc(sample * gain / 65025) for both channels,
// division by reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module pvm_scaler (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pvm_pkg::pvm_scl_req_t req,
    output logic                  done,
    output logic signed [16:0]    q_left,
    output logic signed [16:0]    q_right
);
    import pvm_pkg::*;

    logic [2:0] vld_reg;

    logic [31:0]        mag1_reg [2];
    logic               neg1_reg [2];
    logic [31:0]        mag2_reg [2];
    logic [16:0]        quo2_reg [2];
    logic               neg2_reg [2];
    logic signed [16:0] q3_reg   [2];

    logic signed [15:0] smp     [2];
    logic [15:0]        gain    [2];
    logic [16:0]        smag    [2];
    logic [31:0]        mag1_nx [2];
    logic [48:0]        prod2   [2];
    logic [32:0]        rem3    [2];
    logic [16:0]        q3u     [2];
    logic signed [16:0] q3_nx   [2];

    assign smp[0]  = req.left;
    assign smp[1]  = req.right;
    assign gain[0] = req.gain_l;
    assign gain[1] = req.gain_r;

    // Per-channel datapath
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            smag[c]    = smp[c][15] ? 17'(-{smp[c][15], smp[c]}) : 17'({1'b0, smp[c]});
            mag1_nx[c] = 32'(smag[c]) * 32'(gain[c]);
            prod2[c]   = 49'(mag1_reg[c]) * 49'(GAIN_RECIP);
            rem3[c]    = 33'(mag2_reg[c]) - 33'(quo2_reg[c]) * 33'(GAIN_FULL);
            q3u[c]     = (rem3[c] >= 33'(GAIN_FULL)) ? 17'(quo2_reg[c] + 1'b1)
                                                     : quo2_reg[c];
            q3_nx[c]   = neg2_reg[c] ? -signed'(q3u[c]) : signed'(q3u[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            mag1_reg[c] <= mag1_nx[c];
            neg1_reg[c] <= smp[c][15];
            mag2_reg[c] <= mag1_reg[c];
            quo2_reg[c] <= prod2[c][48:32];
            neg2_reg[c] <= neg1_reg[c];
            q3_reg[c]   <= q3_nx[c];
        end
    end

    assign done    = vld_reg[2];
    assign q_left  = q3_reg[0];
    assign q_right = q3_reg[1];

endmodule

### hdl/pcm_voice_mixer_top.sv
// ----------------------------------------------------------------------------
// pcm_voice_mixer_top
// Multi-voice stereo PCM mixer with per-voice volume and pan.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out; commands are handled one at a
// time. Define runs the step divider (one step-divider bit per cycle). A
// tick visits each voice: for a voice that sounds, voice, sound and sample
// memory reads in turn, then the three-stage gain scaler; for a voice
// already past its end, only the voice and sound reads. Sample frames, the
// sound table and the voice table each sit in a synchronous RAM; a tick
// reads voice i and writes the survivors back compacted. Sample memory
// contents are undefined after reset; sound validity clears at reset.
// ----------------------------------------------------------------------------
module pcm_voice_mixer_top #(
    parameter int MAX_VOICES    = pvm_pkg::MAX_VOICES_DEF,
    parameter int MAX_SOUNDS    = pvm_pkg::MAX_SOUNDS_DEF,
    parameter int SAMPLE_FRAMES = pvm_pkg::SAMPLE_FRAMES_DEF,
    parameter int FRAC_BITS     = pvm_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  pvm_pkg::pvm_item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output pvm_pkg::pvm_result_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pvm_pkg::*;

    localparam int VCW = $clog2(MAX_VOICES + 1);
    localparam int VAW = MAX_VOICES > 1 ? $clog2(MAX_VOICES) : 1;
    localparam int SAW = MAX_SOUNDS > 1 ? $clog2(MAX_SOUNDS) : 1;
    localparam int MAW = SAMPLE_FRAMES > 1 ? $clog2(SAMPLE_FRAMES) : 1;
    localparam int PW  = FRAC_BITS + 17;

    typedef struct packed {
        logic [5:0]    sound;
        logic [PW-1:0] pos;
        logic [31:0]   step;
        logic [7:0]    vol;
        logic [7:0]    pan;
    } voice_t;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEF_ZW  = 4'd1;
    localparam logic [3:0] S_DEF_DIV = 4'd2;
    localparam logic [3:0] S_PLAY_WR = 4'd3;
    localparam logic [3:0] S_TV_RD   = 4'd4;
    localparam logic [3:0] S_TV_VOC  = 4'd5;
    localparam logic [3:0] S_TV_SND  = 4'd6;
    localparam logic [3:0] S_TV_SMP  = 4'd7;
    localparam logic [3:0] S_TV_SCL  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]             state_reg, state_next;
    pvm_item_t              item_reg;
    logic [1:0]             status_reg, status_next;
    logic signed [15:0]     mix_l_reg, mix_l_next;
    logic signed [15:0]     mix_r_reg, mix_r_next;
    logic [VCW-1:0]         cnt_reg, cnt_next;
    logic [VCW-1:0]         idx_reg, idx_next;
    logic [VCW-1:0]         kept_reg, kept_next;
    logic [MAX_SOUNDS-1:0]  snd_valid_reg, snd_valid_next;
    logic [17:0]            orate_reg;
    voice_t                 voice_reg;
    logic [16:0]            len_reg;
    logic                   smp_ok_reg;
    logic [15:0]            gain_l_reg;
    logic [15:0]            gain_r_reg;
    pvm_result_t            result_reg;
    logic                   result_valid_reg;

    // RAM ports
    logic                   snd_we;
    logic [SAW-1:0]         snd_waddr, snd_raddr;
    pvm_sound_t             snd_wdata, snd_rdata;
    logic                   voc_we;
    logic [VAW-1:0]         voc_waddr, voc_raddr;
    voice_t                 voc_wdata, voc_rdata;
    logic                   smp_we;
    logic [MAW-1:0]         smp_waddr, smp_raddr;
    logic [31:0]            smp_wdata, smp_rdata;

    pvm_div_req_t           div_req;
    logic                   div_done;
    logic [31:0]            div_step;
    pvm_scl_req_t           scl_req;
    logic                   scl_done;
    logic signed [16:0]     q_left, q_right;

    // Decode helpers
    logic                   accept;
    logic                   item_sid_ok, item_known;
    logic [SAW-1:0]         item_sidx, voc_sidx;
    logic                   voc_known;
    logic [16:0]            len_cur;
    logic [63:0]            pos_sum;
    logic                   keep;
    logic [31:0]            smp_addr;
    logic [VCW-1:0]         idx_inc;
    logic signed [17:0]     sum_l, sum_r;
    logic [31:0]            cnt_x;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v < MIX_MIN)
        begin
            r = 16'(MIX_MIN);
        end
        else if (v > MIX_MAX)
        begin
            r = 16'(MIX_MAX);
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign accept      = item_valid && item_ready;
    assign item_ready  = (state_reg == S_IDLE);
    assign item_sidx   = SAW'(16'(item.sound_id));
    assign item_sid_ok = 32'(item.sound_id) < 32'(MAX_SOUNDS);
    assign item_known  = item_sid_ok && snd_valid_reg[item_sidx];
    assign voc_sidx    = SAW'(16'(voc_rdata.sound));
    assign idx_inc     = idx_reg + 1'b1;
    assign pos_sum     = 64'(voice_reg.pos) + 64'(voice_reg.step);
    assign keep        = (pos_sum >> FRAC_BITS) < 64'(len_reg);
    assign sum_l       = 18'(mix_l_reg) + 18'(q_left);
    assign sum_r       = 18'(mix_r_reg) + 18'(q_right);
    assign smp_addr    = 32'(snd_rdata.start) + 32'(voice_reg.pos[PW-1:FRAC_BITS]);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orate_reg <= RATE_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_OUTPUT_RATE))
        begin
            orate_reg <= pwdata[17:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_RATE) ? 32'(orate_reg) : 32'd0;

    // Memory port steering
    always_comb
    begin
        snd_raddr = (state_reg == S_TV_VOC) ? voc_sidx : item_sidx;
        snd_we    = 1'b0;
        snd_waddr = SAW'(16'(item_reg.sound_id));
        snd_wdata = snd_rdata;
        if (state_reg == S_DEF_ZW)
        begin
            snd_we        = 1'b1;
            snd_wdata.len = '0;
        end
        else if ((state_reg == S_DEF_DIV) && div_done)
        begin
            snd_we    = 1'b1;
            snd_wdata = '{start: item_reg.start_frame, len: item_reg.length_frames,
                          step: div_step};
        end

        voc_raddr = idx_reg[VAW-1:0];
        voc_we    = 1'b0;
        voc_waddr = kept_reg[VAW-1:0];
        voc_wdata = voice_reg;
        voc_wdata.pos = PW'(pos_sum);
        if (state_reg == S_PLAY_WR)
        begin
            voc_we    = 1'b1;
            voc_waddr = cnt_reg[VAW-1:0];
            voc_wdata = '{sound: item_reg.sound_id, pos: '0, step: snd_rdata.step,
                          vol: item_reg.volume, pan: item_reg.pan};
        end
        else if ((state_reg == S_TV_SCL) && scl_done && keep)
        begin
            voc_we = 1'b1;
        end

        smp_we    = accept && (item.command == CMD_LOAD) &&
                    (32'(item.frame_address) < 32'(SAMPLE_FRAMES));
        smp_waddr = MAW'(32'(item.frame_address));
        smp_wdata = {item.right_sample, item.left_sample};
        smp_raddr = MAW'(smp_addr);
    end

    // Requests to the divider and scaler
    assign div_req.start = accept && (item.command == CMD_DEFINE) && item_sid_ok &&
                           (item.length_frames != '0) &&
                           (32'(item.start_frame) + 32'(item.length_frames)
                            <= 32'(SAMPLE_FRAMES));
    assign div_req.rate  = item.src_rate;
    assign div_req.orate = orate_reg;

    assign scl_req.start  = (state_reg == S_TV_SMP);
    assign scl_req.left   = smp_ok_reg ? signed'(smp_rdata[15:0]) : '0;
    assign scl_req.right  = smp_ok_reg ? signed'(smp_rdata[31:16]) : '0;
    assign scl_req.gain_l = gain_l_reg;
    assign scl_req.gain_r = gain_r_reg;

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        mix_l_next     = mix_l_reg;
        mix_r_next     = mix_r_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        snd_valid_next = snd_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    mix_l_next  = '0;
                    mix_r_next  = '0;
                    idx_next    = '0;
                    kept_next   = '0;
                    state_next  = S_DONE;
                    case (item.command)
                        CMD_LOAD:
                        begin
                            if (!smp_we)
                            begin
                                status_next = STAT_RANGE;
                            end
                        end
                        CMD_DEFINE:
                        begin
                            if (!item_sid_ok)
                            begin
                                status_next = STAT_UNKNOWN;
                            end
                            else if (item.length_frames == '0)
                            begin
                                if (item_known)
                                begin
                                    state_next = S_DEF_ZW;
                                end
                            end
                            else if (div_req.start)
                            begin
                                state_next = S_DEF_DIV;
                            end
                            else
                            begin
                                status_next = STAT_RANGE;
                            end
                        end
                        CMD_PLAY:
                        begin
                            if (!item_known)
                            begin
                                status_next = STAT_UNKNOWN;
                            end
                            else if (cnt_reg >= VCW'(MAX_VOICES))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_PLAY_WR;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = S_TV_RD;
                            end
                        end
                    endcase
                end
            end
            S_DEF_ZW:
            begin
                state_next = S_DONE;
            end
            S_DEF_DIV:
            begin
                if (div_done)
                begin
                    snd_valid_next[SAW'(16'(item_reg.sound_id))] = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_PLAY_WR:
            begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_DONE;
            end
            S_TV_RD:
            begin
                state_next = S_TV_VOC;
            end
            S_TV_VOC:
            begin
                state_next = S_TV_SND;
            end
            S_TV_SND:
            begin
                if (voice_reg.pos[PW-1:FRAC_BITS] < len_cur)
                begin
                    state_next = S_TV_SMP;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_TV_RD;
                    if (idx_inc >= cnt_reg)
                    begin
                        cnt_next   = kept_reg;
                        state_next = S_DONE;
                    end
                end
            end
            S_TV_SMP:
            begin
                state_next = S_TV_SCL;
            end
            S_TV_SCL:
            begin
                if (scl_done)
                begin
                    mix_l_next = sat16(sum_l);
                    mix_r_next = sat16(sum_r);
                    kept_next  = keep ? VCW'(kept_reg + 1'b1) : kept_reg;
                    idx_next   = idx_inc;
                    state_next = S_TV_RD;
                    if (idx_inc >= cnt_reg)
                    begin
                        cnt_next   = kept_next;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            status_reg       <= STAT_OK;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            kept_reg         <= '0;
            snd_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            snd_valid_reg <= snd_valid_next;
            if ((state_reg == S_DONE) && (!result_valid_reg || result_ready))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    assign cnt_x     = 32'(cnt_reg);
    assign voc_known = (32'(voice_reg.sound) < 32'(MAX_SOUNDS)) &&
                       snd_valid_reg[SAW'(16'(voice_reg.sound))];

    // Length of this voice's sound, straight from the table read; zero if unknown
    assign len_cur   = voc_known ? snd_rdata.len : '0;

    always_ff @(posedge clk)
    begin
        mix_l_reg <= mix_l_next;
        mix_r_reg <= mix_r_next;
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == S_TV_VOC)
        begin
            voice_reg <= voc_rdata;
        end
        if (state_reg == S_TV_SND)
        begin
            len_reg    <= len_cur;
            smp_ok_reg <= smp_addr < 32'(SAMPLE_FRAMES);
            gain_l_reg <= 16'(voice_reg.vol) * 16'(PAN_FULL - voice_reg.pan);
            gain_r_reg <= 16'(voice_reg.vol) * 16'(voice_reg.pan);
        end
        if ((state_reg == S_DONE) && (!result_valid_reg || result_ready))
        begin
            result_reg <= '{out_left: mix_l_reg, out_right: mix_r_reg,
                            status: status_reg, active_voices: cnt_x[4:0]};
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    pvm_ram #(.WIDTH(32), .DEPTH(SAMPLE_FRAMES)) u_sample_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (smp_wdata),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    pvm_ram #(.WIDTH($bits(pvm_sound_t)), .DEPTH(MAX_SOUNDS)) u_sound_ram (
        .clk   (clk),
        .we    (snd_we),
        .waddr (snd_waddr),
        .wdata (snd_wdata),
        .raddr (snd_raddr),
        .rdata (snd_rdata)
    );

    pvm_ram #(.WIDTH($bits(voice_t)), .DEPTH(MAX_VOICES)) u_voice_ram (
        .clk   (clk),
        .we    (voc_we),
        .waddr (voc_waddr),
        .wdata (voc_wdata),
        .raddr (voc_raddr),
        .rdata (voc_rdata)
    );

    pvm_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .step  (div_step)
    );

    pvm_scaler u_scaler (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scl_req),
        .done    (scl_done),
        .q_left  (q_left),
        .q_right (q_right)
    );

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= VCW'(MAX_VOICES))
        else $error("voice count beyond table size");

    a_kept_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= idx_reg)
        else $error("compaction write ahead of read");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted beat left no work");

    a_scl_state: assert property (@(posedge clk) disable iff (!rst_n)
        scl_done |-> (state_reg == S_TV_SCL))
        else $error("scaler result outside mix state");

endmodule
